FILE: rtl/core/radix_prefixed_integer_parser_core_assert.svh
// Assertion macros for the radix prefixed integer parser.
// Each macro samples on the rising edge of clock.
`ifndef RADIX_PREFIXED_INTEGER_PARSER_CORE_ASSERT_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_CORE_ASSERT_SVH

// Checked only outside reset.
`define RPIP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define RPIP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/rpip_pkg.sv
// ----------------------------------------------------------------------------
// rpip_pkg
// Shared types and character codes for the integer parser.
// ----------------------------------------------------------------------------
package rpip_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned DIGIT_W = 4;

   typedef enum logic [2:0] {
      PH_WS     = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_OCT = 2'd2,
      RX_BIN = 2'd3
   } radix_type;

   typedef struct packed {
      logic               ok;
      logic [DIGIT_W-1:0] val;
   } digit_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               error;
   } result_type;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ONE     = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_EIGHT   = 8'h38;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_B = 8'h42;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_B = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;

   localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

endpackage

FILE: rtl/core/rpip_digit.sv
// ----------------------------------------------------------------------------
// rpip_digit
// Classifies one character as a digit of the selected radix.
// ----------------------------------------------------------------------------
module rpip_digit (
   input  rpip_pkg::radix_type              radix,
   input  logic [rpip_pkg::CHAR_W-1:0]      char_code,
   output rpip_pkg::digit_type              digit
);
   import rpip_pkg::*;

   logic                is_dec;
   logic                is_upper;
   logic                is_lower;
   logic [CHAR_W-1:0]   upper_off;
   logic [CHAR_W-1:0]   lower_off;

   assign is_dec    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_upper  = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
   assign is_lower  = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
   assign upper_off = char_code - CHAR_UPPER_A;
   assign lower_off = char_code - CHAR_LOWER_A;

   always_comb begin
      digit.ok  = 1'b0;
      digit.val = char_code[DIGIT_W-1:0];
      unique case (radix)
         RX_DEC: begin
            digit.ok = is_dec;
         end
         RX_HEX: begin
            if (is_dec) begin
               digit.ok = 1'b1;
            end else if (is_upper) begin
               digit.ok  = 1'b1;
               digit.val = upper_off[DIGIT_W-1:0] + HEX_LETTER_BASE;
            end else if (is_lower) begin
               digit.ok  = 1'b1;
               digit.val = lower_off[DIGIT_W-1:0] + HEX_LETTER_BASE;
            end
         end
         RX_OCT: begin
            digit.ok = (char_code >= CHAR_ZERO) && (char_code < CHAR_EIGHT);
         end
         RX_BIN: begin
            digit.ok = (char_code == CHAR_ZERO) || (char_code == CHAR_ONE);
         end
         default: begin
            digit.ok = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/core/rpip_parser.sv
// ----------------------------------------------------------------------------
// rpip_parser
// Parse state and accumulator, advanced by one character per step.
// ----------------------------------------------------------------------------
module rpip_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [rpip_pkg::CHAR_W-1:0]      char_code,
   output rpip_pkg::result_type             result
);
   import rpip_pkg::*;

   phase_type            phase_ff, phase_in;
   radix_type            radix_ff, radix_in;
   radix_type            take_radix;
   logic                 neg_ff, neg_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic                 err_ff, err_in;
   logic                 take;
   logic                 is_ws;
   logic [VALUE_W-1:0]   scaled;
   digit_type            digit;

   rpip_digit u_digit (
      .radix     (take_radix),
      .char_code (char_code),
      .digit     (digit)
   );

   assign is_ws = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                  (char_code == CHAR_CR) || (char_code == CHAR_LF);

   // radix in force for a digit taken in the current phase
   always_comb begin
      unique case (phase_ff)
         PH_WS, PH_SIGNED: take_radix = RX_DEC;
         PH_ZERO:          take_radix = RX_OCT;
         default:          take_radix = radix_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         radix_ff <= RX_DEC;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      unique case (take_radix)
         RX_DEC:  scaled = (acc_ff << 3) + (acc_ff << 1);
         RX_HEX:  scaled = acc_ff << 4;
         RX_OCT:  scaled = acc_ff << 3;
         RX_BIN:  scaled = acc_ff << 1;
         default: scaled = acc_ff;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      take     = 1'b0;

      if (char_code == CHAR_NUL) begin
         phase_in = PH_WS;
         radix_in = RX_DEC;
         neg_in   = 1'b0;
         acc_in   = '0;
         err_in   = 1'b0;
      end else if (!err_ff) begin
         unique case (phase_ff)
            PH_WS: begin
               priority if (is_ws) begin
                  phase_in = PH_WS;
               end else if (char_code == CHAR_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGNED;
               end else if (char_code == CHAR_PLUS) begin
                  phase_in = PH_SIGNED;
               end else if (char_code == CHAR_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  radix_in = RX_DEC;
                  phase_in = PH_DIGITS;
                  take     = 1'b1;
               end
            end
            PH_SIGNED: begin
               if (char_code == CHAR_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  radix_in = RX_DEC;
                  phase_in = PH_DIGITS;
                  take     = 1'b1;
               end
            end
            PH_ZERO: begin
               phase_in = PH_DIGITS;
               priority if ((char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X)) begin
                  radix_in = RX_HEX;
               end else if ((char_code == CHAR_LOWER_B) || (char_code == CHAR_UPPER_B)) begin
                  radix_in = RX_BIN;
               end else begin
                  // the leading zero already counts as an octal digit
                  radix_in = RX_OCT;
                  take     = 1'b1;
               end
            end
            default: begin
               take = 1'b1;
            end
         endcase

         if (take) begin
            if (digit.ok) begin
               acc_in = scaled + {{(VALUE_W-DIGIT_W){1'b0}}, digit.val};
            end else begin
               err_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.error = err_ff;
      if (err_ff) begin
         result.value = '0;
      end else if (neg_ff) begin
         result.value = {VALUE_W{1'b0}} - acc_ff;
      end else begin
         result.value = acc_ff;
      end
   end

endmodule

FILE: rtl/core/radix_prefixed_integer_parser_core.sv
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser_core
// Auto-radix integer parser, one character per request.
// ----------------------------------------------------------------------------
// A taken NUL is held in the input register, then stored in the response register.
// Throughput: one character per cycle, with the accumulator updated on each step.
// Only a NUL waits on a stalled response register; other characters never do.
// Reset (synchronous): clears parse state, accumulator, error and both valid flags.
module radix_prefixed_integer_parser_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpip_pkg::CHAR_W-1:0]         req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rpip_pkg::VALUE_W-1:0] rsp_parsed_value,
   output logic                                rsp_parse_error
);
   import rpip_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]    char_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   result_type           result;
   logic                 req_take;
   logic                 out_free;
   logic                 is_nul;
   logic                 step;

   rpip_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (char_ff),
      .result    (result)
   );

   assign is_nul    = (char_ff == CHAR_NUL);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!is_nul || out_free);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step && is_nul) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_char_code;
      end
      if (step && is_nul) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_parsed_value = out_ff.value;
   assign rsp_parse_error  = out_ff.error;

endmodule

FILE: rtl/core/rpip_checker.sv
// ----------------------------------------------------------------------------
// rpip_checker
// Port-level checks on the integer parser core.
// ----------------------------------------------------------------------------
`include "radix_prefixed_integer_parser_core_assert.svh"

module rpip_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [rpip_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [rpip_pkg::VALUE_W-1:0] rsp_parsed_value,
   input  logic                                rsp_parse_error
);
   import rpip_pkg::*;

   `RPIP_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_valid && !req_stall), "reset did not clear handshake state")
   // with the response register empty every request can move on
   `RPIP_ASSERT(a_no_stall_when_empty, (!rsp_valid) |-> (!req_stall), "request stalled with empty response register")
   `RPIP_ASSERT(a_error_zero_value, (rsp_valid && rsp_parse_error) |-> (rsp_parsed_value == '0), "error response with nonzero value")
   `RPIP_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_parsed_value) && $stable(rsp_parse_error)), "stalled response changed")
   `RPIP_ASSERT(a_req_hold, (req_valid && req_stall) |=> (req_valid && $stable(req_char_code)), "stalled request changed")

endmodule

bind radix_prefixed_integer_parser_core rpip_checker u_rpip_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_char_code    (req_char_code),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_parsed_value (rsp_parsed_value),
   .rsp_parse_error  (rsp_parse_error)
);

FILE: dv/radix_prefixed_integer_parser_core_tb.sv
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser_core_tb
// Self-checking bench for the auto-radix integer parser. Strings go in one
// character per request, each closed by a NUL. A scoreboard follows the parse
// on every accepted character, builds the value and error it expects at each
// NUL, and compares them in order with the responses. A few hand-picked
// strings come first. Random strings follow: mostly well-formed numbers in all
// four radixes, some with a stray byte, and some pure noise. Idling moves
// between the sender and the receiver, and one long response stall is
// included.
// ----------------------------------------------------------------------------
module radix_prefixed_integer_parser_core_tb;
   import rpip_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 300;
   localparam int CHARS_PER_SET = 600;

   class parse_scoreboard;
      phase_type            phase;
      radix_type            radix;
      bit                   negative;
      logic [VALUE_W-1:0]   acc;
      bit                   err;
      result_type           expected_q[$];
      int                   failures;
      int                   results_checked;
      int                   error_results;

      function new();
         clear();
         failures        = 0;
         results_checked = 0;
         error_results   = 0;
      endfunction

      function void clear();
         phase    = PH_WS;
         radix    = RX_DEC;
         negative = 1'b0;
         acc      = '0;
         err      = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void add_digit(logic [CHAR_W-1:0] c);
         logic [DIGIT_W-1:0] d;
         bit                 ok;
         d  = '0;
         ok = 1'b0;
         case (radix)
            RX_DEC: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  d  = DIGIT_W'(c - CHAR_ZERO);
                  ok = 1'b1;
               end
            end
            RX_HEX: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  d  = DIGIT_W'(c - CHAR_ZERO);
                  ok = 1'b1;
               end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
                  d  = DIGIT_W'(c - CHAR_UPPER_A) + HEX_LETTER_BASE;
                  ok = 1'b1;
               end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
                  d  = DIGIT_W'(c - CHAR_LOWER_A) + HEX_LETTER_BASE;
                  ok = 1'b1;
               end
            end
            RX_OCT: begin
               if (c >= CHAR_ZERO && c < CHAR_EIGHT) begin
                  d  = DIGIT_W'(c - CHAR_ZERO);
                  ok = 1'b1;
               end
            end
            default: begin
               if (c == CHAR_ZERO || c == CHAR_ONE) begin
                  d  = DIGIT_W'(c - CHAR_ZERO);
                  ok = 1'b1;
               end
            end
         endcase
         if (!ok) begin
            err = 1'b1;
         end else begin
            case (radix)
               RX_DEC:  acc = acc * 64'd10 + VALUE_W'(d);
               RX_HEX:  acc = (acc << 4) + VALUE_W'(d);
               RX_OCT:  acc = (acc << 3) + VALUE_W'(d);
               default: acc = (acc << 1) + VALUE_W'(d);
            endcase
         end
      endfunction

      function void note_char(logic [CHAR_W-1:0] c);
         result_type r;
         if (c == CHAR_NUL) begin
            r.value = negative ? -acc : acc;
            if (err) r.value = '0;
            r.error = err;
            expected_q.push_back(r);
            clear();
            return;
         end
         // once invalid, everything up to the NUL is ignored
         if (err) return;
         case (phase)
            PH_WS: begin
               if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
               end else if (c == CHAR_MINUS) begin
                  negative = 1'b1;
                  phase    = PH_SIGNED;
               end else if (c == CHAR_PLUS) begin
                  phase = PH_SIGNED;
               end else if (c == CHAR_ZERO) begin
                  phase = PH_ZERO;
               end else begin
                  radix = RX_DEC;
                  phase = PH_DIGITS;
                  add_digit(c);
               end
            end
            PH_SIGNED: begin
               if (c == CHAR_ZERO) begin
                  phase = PH_ZERO;
               end else begin
                  radix = RX_DEC;
                  phase = PH_DIGITS;
                  add_digit(c);
               end
            end
            PH_ZERO: begin
               phase = PH_DIGITS;
               if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
                  radix = RX_HEX;
               end else if (c == CHAR_LOWER_B || c == CHAR_UPPER_B) begin
                  radix = RX_BIN;
               end else begin
                  // bare leading zero: octal, and the zero counts as a digit
                  radix = RX_OCT;
                  add_digit(c);
               end
            end
            default: add_digit(c);
         endcase
      endfunction

      function void check_result(logic [VALUE_W-1:0] value, logic error);
         result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected, value %h error %b",
                     $time, value, error);
            failures++;
            return;
         end
         exp_r = expected_q.pop_front();
         results_checked++;
         if (exp_r.error) error_results++;
         if (value !== exp_r.value) begin
            $display("%0t: parsed_value mismatch, expected %h actual %h",
                     $time, exp_r.value, value);
            failures++;
         end
         if (error !== exp_r.error) begin
            $display("%0t: parse_error mismatch, expected %b actual %b",
                     $time, exp_r.error, error);
            failures++;
         end
      endfunction
   endclass

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic [CHAR_W-1:0]          req_char_code = '0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_parsed_value;
   logic                       rsp_parse_error;

   parse_scoreboard sb = new();

   int  req_idle_pct  = 28;
   int  rsp_stall_pct = 66;
   int  chars_sent    = 0;
   int  cycle_count   = 0;
   bit  long_hold_due = 1'b0;

   radix_prefixed_integer_parser_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_parse_error  (rsp_parse_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** radix_prefixed_integer_parser_core: FAILED **");
         $finish;
      end
   end

   // both channels sampled at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_char(req_char_code);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_parsed_value, rsp_parse_error);
      end
   end

   // response side: random stalls, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] c);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(CHAR_W'(s[i]));
      send_char(CHAR_NUL);
   endtask

   function automatic logic [CHAR_W-1:0] pick_digit(radix_type rx);
      int v;
      case (rx)
         RX_DEC: return CHAR_W'(CHAR_ZERO + $urandom_range(9));
         RX_OCT: return CHAR_W'(CHAR_ZERO + $urandom_range(7));
         RX_BIN: return CHAR_W'(CHAR_ZERO + $urandom_range(1));
         default: begin
            v = $urandom_range(21);
            if (v < 10) return CHAR_W'(CHAR_ZERO + v);
            if (v < 16) return CHAR_W'(CHAR_UPPER_A + v - 10);
            return CHAR_W'(CHAR_LOWER_A + v - 16);
         end
      endcase
   endfunction

   task automatic send_random_string();
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] blanks[4];
      radix_type         rx;
      int                roll;
      int                ndig;
      blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
      roll   = $urandom_range(99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 8)) text.push_back(CHAR_W'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(2)) text.push_back(blanks[$urandom_range(3)]);
         case ($urandom_range(2))
            1: text.push_back(CHAR_PLUS);
            2: text.push_back(CHAR_MINUS);
            default: ;
         endcase
         rx = radix_type'($urandom_range(3));
         // now and then long enough to wrap the accumulator
         ndig = ($urandom_range(9) == 0) ? $urandom_range(17, 70) : $urandom_range(8);
         case (rx)
            RX_HEX: begin
               text.push_back(CHAR_ZERO);
               text.push_back($urandom_range(1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            end
            RX_BIN: begin
               text.push_back(CHAR_ZERO);
               text.push_back($urandom_range(1) ? CHAR_LOWER_B : CHAR_UPPER_B);
            end
            RX_OCT: text.push_back(CHAR_ZERO);
            default: ;
         endcase
         repeat (ndig) text.push_back(pick_digit(rx));
         if (roll < 20) text.insert($urandom_range(text.size()), CHAR_W'($urandom_range(1, 255)));
      end
      foreach (text[i]) send_char(text[i]);
      send_char(CHAR_NUL);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      string directed[$];
      int    target;
      bit    hold_issued;
      bit    drain_done;
      directed = '{"", "\t-", "0X", "-0b1", "07", "0xaF", "9\3775", "+ ", "+-"};
      hold_issued = 1'b0;
      drain_done  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_string(directed[i]);

      for (int set = 0; set < 3; set++) begin
         case (set)
            0: begin req_idle_pct = 28; rsp_stall_pct = 66; end
            1: begin req_idle_pct = 66; rsp_stall_pct = 28; end
            default: begin req_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         target = chars_sent + CHARS_PER_SET;
         while (chars_sent < target) begin
            send_random_string();
            // mid-set: a long response stall in the first, a full drain in the second
            if (set == 0 && !hold_issued && chars_sent >= target - CHARS_PER_SET / 2) begin
               long_hold_due = 1'b1;
               hold_issued   = 1'b1;
            end
            if (set == 1 && !drain_done && chars_sent >= target - CHARS_PER_SET / 2) begin
               wait_drained();
               drain_done = 1'b1;
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d parsed strings (%0d with invalid digits) from %0d characters,",
               sb.results_checked, sb.error_results, chars_sent);
      $display("across all radixes, sender and receiver idling, a long stall and a drain.");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("** radix_prefixed_integer_parser_core: PASSED **");
      end else begin
         $display("** radix_prefixed_integer_parser_core: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rpip_pkg.sv
rtl/core/rpip_digit.sv
rtl/core/rpip_parser.sv
rtl/core/radix_prefixed_integer_parser_core.sv
rtl/core/rpip_checker.sv
dv/radix_prefixed_integer_parser_core_tb.sv
